// ===== rtl/ptw_pkg.sv =====
// Shared types and codes for the four-level page table walker.
// Used by ptw_ctrl, ptw_datapath and the top level; depends on nothing.
`default_nettype none

package ptw_pkg;

   // Operation codes on the request channel
   localparam logic [2:0] FUNC_WRITE = 3'd0;
   localparam logic [2:0] FUNC_READ  = 3'd1;
   localparam logic [2:0] FUNC_XLATE = 3'd2;
   localparam logic [2:0] FUNC_MAP   = 3'd3;
   localparam logic [2:0] FUNC_UNMAP = 3'd4;

   // Response status codes
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_ABSENT   = 2'd1;
   localparam logic [1:0] ST_OUTSIDE  = 2'd2;
   localparam logic [1:0] ST_CONFLICT = 2'd3;

   // Store address sources
   localparam logic [1:0] ADDR_WORD = 2'd0;
   localparam logic [1:0] ADDR_ROOT = 2'd1;
   localparam logic [1:0] ADDR_NEXT = 2'd2;
   localparam logic [1:0] ADDR_POS  = 2'd3;

   // Store write data sources
   localparam logic [1:0] WD_ZERO = 2'd0;
   localparam logic [1:0] WD_WORD = 2'd1;
   localparam logic [1:0] WD_LEAF = 2'd2;

   // Translated address sources
   localparam logic [1:0] RA_NONE  = 2'd0;
   localparam logic [1:0] RA_LARGE = 2'd1;
   localparam logic [1:0] RA_SMALL = 2'd2;

   // Walk levels (level 4 first)
   localparam logic [1:0] LVL_4 = 2'd3;
   localparam logic [1:0] LVL_3 = 2'd2;
   localparam logic [1:0] LVL_2 = 2'd1;
   localparam logic [1:0] LVL_1 = 2'd0;

   // Table geometry and entry layout
   localparam int unsigned ENTRIES_PER_TABLE = 512;
   localparam int unsigned IDX_BITS          = 9;
   localparam int unsigned PRESENT_BIT       = 0;
   localparam int unsigned LARGE_BIT         = 7;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       clr_wr;       // write zero at the clear pointer and advance it
      logic       load;         // capture the request fields
      logic       rd_en;        // read the store, remember the address
      logic [1:0] addr_sel;     // store address source
      logic       wr_en;        // write the store
      logic [1:0] wdata_sel;    // store write data source
      logic       lvl_start;    // begin the walk at level 4
      logic       lvl_down;     // step to the next level
      logic       res_load;     // capture the result
      logic [1:0] res_status;
      logic [1:0] res_addr_sel;
      logic       res_rdata;    // return the read word
      logic       out_load;     // move the result into the response register
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic       clr_last;     // clear pointer at the last word
      logic [2:0] func;
      logic       widx_ok;      // word index inside the store
      logic       root_ok;      // root frame inside the store
      logic       present;      // fetched entry present
      logic       big_page;     // fetched entry marks a large page
      logic       next_ok;      // frame of fetched entry inside the store
      logic [1:0] level;        // level of fetched entry
   } dp_sts_type;

endpackage

`default_nettype wire

// ===== rtl/four_level_page_table_walker_top.sv =====
// Four-level page table walker over a word store: top level.
// Request channel: req_valid/req_stall with func, virtual and physical
// address, flags, word index and word data. Response channel:
// rsp_valid/rsp_stall with status, translated address and read data.
// One request is worked at a time, with one response per request.
// A walk reads table entries one level at a time through the single store port;
// map and unmap end with a write of the leaf entry, and a walk that stops
// early responds sooner. The next request is taken in the cycle after the
// response is loaded.
// The root table frame sits in a register at byte address 0 of the csr_ port.
// Reset: a clearing pass writes zero to every store word, one word per cycle;
// req_stall stays high meanwhile, csr writes are taken. When the receiver stalls,
// the finished result waits in a holding register until the response
// register frees up, and req_stall stays high.
// Depends on ptw_pkg, ptw_ctrl and ptw_datapath.
`default_nettype none

module four_level_page_table_walker_top
   import ptw_pkg::*;
#(
   parameter int unsigned STORE_WORDS = 16384
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [2:0]   req_func,
   input  wire logic [47:0]  req_virt_addr,
   input  wire logic [51:0]  req_phys_addr,
   input  wire logic [11:0]  req_page_flags,
   input  wire logic [13:0]  req_word_index,
   input  wire logic [63:0]  req_word_data,
   // response channel
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [51:0]       rsp_translated_addr,
   output logic [63:0]       rsp_read_data,
   // configuration port
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       cfg_wr;
   logic [4:0] root_frame;

   // Decode the root frame register
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       !csr_paddr[2];
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {27'd0, root_frame};

   ptw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ptw_datapath #(
      .STORE_WORDS (STORE_WORDS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .cfg_wr              (cfg_wr),
      .cfg_root            (csr_pwdata[4:0]),
      .root_frame          (root_frame),
      .req_func            (req_func),
      .req_virt_addr       (req_virt_addr),
      .req_phys_addr       (req_phys_addr),
      .req_page_flags      (req_page_flags),
      .req_word_index      (req_word_index),
      .req_word_data       (req_word_data),
      .rsp_status          (rsp_status),
      .rsp_translated_addr (rsp_translated_addr),
      .rsp_read_data       (rsp_read_data)
   );

endmodule

`default_nettype wire

// ===== rtl/ptw_datapath.sv =====
// Datapath of the page table walker: request registers, table store,
// walk position, result and response registers. Depends on ptw_pkg.
`default_nettype none

module ptw_datapath
   import ptw_pkg::*;
#(
   parameter int unsigned STORE_WORDS = 16384
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire dp_cmd_type   cmd,
   output dp_sts_type        sts,
   input  wire logic         cfg_wr,
   input  wire logic [4:0]   cfg_root,
   output logic [4:0]        root_frame,
   input  wire logic [2:0]   req_func,
   input  wire logic [47:0]  req_virt_addr,
   input  wire logic [51:0]  req_phys_addr,
   input  wire logic [11:0]  req_page_flags,
   input  wire logic [13:0]  req_word_index,
   input  wire logic [63:0]  req_word_data,
   output logic [1:0]        rsp_status,
   output logic [51:0]       rsp_translated_addr,
   output logic [63:0]       rsp_read_data
);

   localparam int unsigned AW          = $clog2(STORE_WORDS);
   localparam int unsigned FRAME_COUNT = STORE_WORDS / ENTRIES_PER_TABLE;

   // Request registers
   logic [2:0]  func_ff;
   logic [47:0] va_ff;
   logic [39:0] pa_ff;
   logic [11:0] flags_ff;
   logic [13:0] widx_ff;
   logic [63:0] wdata_ff;

   // Walk and store registers
   logic [4:0]    root_ff;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] pos_ff;
   logic [1:0]    level_ff;
   logic [63:0]   mem_q_ff;
   logic [63:0]   store_mem [STORE_WORDS];

   // Result and response registers
   logic [1:0]  res_status_ff;
   logic [51:0] res_addr_ff;
   logic [63:0] res_rdata_ff;
   logic [1:0]  out_status_ff;
   logic [51:0] out_addr_ff;
   logic [63:0] out_rdata_ff;

   logic [39:0]         next_frame;
   logic [1:0]          next_level;
   logic [IDX_BITS-1:0] root_idx;
   logic [IDX_BITS-1:0] next_idx;
   logic [AW-1:0]       root_pos;
   logic [AW-1:0]       next_pos;
   logic [AW-1:0]       mem_addr;
   logic [63:0]         mem_wdata;
   logic [51:0]         res_addr_in;

   // Pick the 9-bit table index of a level from the virtual address
   function automatic logic [IDX_BITS-1:0] level_idx(input logic [47:0] va,
                                                     input logic [1:0]  lvl);
      logic [IDX_BITS-1:0] idx;
      case (lvl)
         LVL_4:   idx = va[47:39];
         LVL_3:   idx = va[38:30];
         LVL_2:   idx = va[29:21];
         default: idx = va[20:12];
      endcase
      return idx;
   endfunction

   // Entry positions for the root table and for the table a fetched entry names
   assign next_frame = mem_q_ff[51:12];
   assign next_level = level_ff - 2'd1;
   assign root_idx   = level_idx(va_ff, LVL_4);
   assign next_idx   = level_idx(va_ff, next_level);
   assign root_pos   = AW'({root_ff, root_idx});
   assign next_pos   = AW'({next_frame, next_idx});

   // Select store address and write data
   always_comb begin
      if (cmd.clr_wr) begin
         mem_addr = clr_addr_ff;
      end else begin
         case (cmd.addr_sel)
            ADDR_WORD: mem_addr = AW'(widx_ff);
            ADDR_ROOT: mem_addr = root_pos;
            ADDR_NEXT: mem_addr = next_pos;
            default:   mem_addr = pos_ff;
         endcase
      end
      case (cmd.wdata_sel)
         WD_WORD: mem_wdata = wdata_ff;
         WD_LEAF: mem_wdata = {12'd0, pa_ff, flags_ff[11:1], 1'b1};
         default: mem_wdata = 64'd0;
      endcase
   end

   // Table store: one port, registered read
   always_ff @(posedge clock) begin
      if (cmd.clr_wr || cmd.wr_en) begin
         store_mem[mem_addr] <= cmd.clr_wr ? 64'd0 : mem_wdata;
      end
      if (cmd.rd_en) begin
         mem_q_ff <= store_mem[mem_addr];
      end
   end

   // Advance the clear pointer, hold the root frame
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         root_ff     <= 5'd0;
      end else begin
         if (cmd.clr_wr) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
         if (cfg_wr) begin
            root_ff <= cfg_root;
         end
      end
   end

   // Capture the request, track the walk position and level
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         va_ff    <= req_virt_addr;
         pa_ff    <= req_phys_addr[51:12];
         flags_ff <= req_page_flags;
         widx_ff  <= req_word_index;
         wdata_ff <= req_word_data;
      end
      if (cmd.rd_en) begin
         pos_ff <= mem_addr;
      end
      if (cmd.lvl_start) begin
         level_ff <= LVL_4;
      end else if (cmd.lvl_down) begin
         level_ff <= next_level;
      end
   end

   // Form the translated address
   always_comb begin
      case (cmd.res_addr_sel)
         RA_LARGE: res_addr_in = {mem_q_ff[51:21], va_ff[20:0]};
         RA_SMALL: res_addr_in = {mem_q_ff[51:12], va_ff[11:0]};
         default:  res_addr_in = 52'd0;
      endcase
   end

   // Hold the result, then hand it to the response register
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_addr_ff   <= res_addr_in;
         res_rdata_ff  <= cmd.res_rdata ? mem_q_ff : 64'd0;
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_addr_ff   <= res_addr_ff;
         out_rdata_ff  <= res_rdata_ff;
      end
   end

   // Status toward the controller
   assign sts.clr_last = (clr_addr_ff == AW'(STORE_WORDS - 1));
   assign sts.func     = func_ff;
   assign sts.widx_ok  = ({18'd0, widx_ff} < 32'(STORE_WORDS));
   assign sts.root_ok  = ({35'd0, root_ff} < 40'(FRAME_COUNT));
   assign sts.present  = mem_q_ff[PRESENT_BIT];
   assign sts.big_page = mem_q_ff[LARGE_BIT];
   assign sts.next_ok  = (next_frame < 40'(FRAME_COUNT));
   assign sts.level    = level_ff;

   assign root_frame          = root_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_translated_addr = out_addr_ff;
   assign rsp_read_data       = out_rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/ptw_ctrl.sv =====
// Controller of the page table walker: clearing pass, request sequencing,
// walk decisions and response valid. Depends on ptw_pkg.
`default_nettype none

module ptw_ctrl
   import ptw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   input  wire dp_sts_type  sts,
   output dp_cmd_type       cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_START  = 3'd2;
   localparam logic [2:0] S_RDWORD = 3'd3;
   localparam logic [2:0] S_WALK   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       is_word_op;
   logic       is_walk_op;

   assign is_word_op = (sts.func == FUNC_WRITE) || (sts.func == FUNC_READ);
   assign is_walk_op = (sts.func == FUNC_XLATE) || (sts.func == FUNC_MAP) ||
                       (sts.func == FUNC_UNMAP);

   // Sequence the request and issue datapath commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            state_in       = S_FINISH;
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_DONE;
            if (is_word_op) begin
               if (!sts.widx_ok) begin
                  cmd.res_status = ST_OUTSIDE;
               end else if (sts.func == FUNC_WRITE) begin
                  cmd.wr_en     = 1'b1;
                  cmd.addr_sel  = ADDR_WORD;
                  cmd.wdata_sel = WD_WORD;
               end else begin
                  cmd.res_load = 1'b0;
                  cmd.rd_en    = 1'b1;
                  cmd.addr_sel = ADDR_WORD;
                  state_in     = S_RDWORD;
               end
            end else if (is_walk_op) begin
               if (!sts.root_ok) begin
                  cmd.res_status = ST_OUTSIDE;
               end else begin
                  cmd.res_load  = 1'b0;
                  cmd.rd_en     = 1'b1;
                  cmd.addr_sel  = ADDR_ROOT;
                  cmd.lvl_start = 1'b1;
                  state_in      = S_WALK;
               end
            end
         end
         S_RDWORD: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_DONE;
            cmd.res_rdata  = 1'b1;
            state_in       = S_FINISH;
         end
         S_WALK: begin
            // Defaults: finish with done; cases below override
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_DONE;
            state_in       = S_FINISH;
            if (!sts.present) begin
               cmd.res_status = ST_ABSENT;
            end else if (sts.level == LVL_1) begin
               cmd.res_addr_sel = RA_SMALL;
            end else if (sts.level == LVL_2 && sts.big_page) begin
               // Large page: translate, refuse map, clear on unmap
               if (sts.func == FUNC_XLATE) begin
                  cmd.res_addr_sel = RA_LARGE;
               end else if (sts.func == FUNC_MAP) begin
                  cmd.res_status = ST_CONFLICT;
               end else begin
                  cmd.wr_en     = 1'b1;
                  cmd.addr_sel  = ADDR_POS;
                  cmd.wdata_sel = WD_ZERO;
               end
            end else if (!sts.next_ok) begin
               cmd.res_status = ST_OUTSIDE;
            end else if (sts.level != LVL_2 || sts.func == FUNC_XLATE) begin
               // Descend one level
               cmd.res_load = 1'b0;
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ADDR_NEXT;
               cmd.lvl_down = 1'b1;
               state_in     = S_WALK;
            end else begin
               // Write the leaf entry for map or unmap
               cmd.wr_en     = 1'b1;
               cmd.addr_sel  = ADDR_NEXT;
               cmd.wdata_sel = (sts.func == FUNC_MAP) ? WD_LEAF : WD_ZERO;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Set response valid on load, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
